/* rtl/bounded_linked_list_engine_defines.svh */
// Assertion helpers shared by the engine's RTL.
`ifndef BOUNDED_LINKED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_LINKED_LIST_ENGINE_DEFINES_SVH

// Check that post holds in the same cycle as pre.
`define BLL_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Check that post holds in the cycle after pre.
`define BLL_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/bll_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bll_pkg;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_BACK  = 3'd3,
    CMD_DEL_AT    = 3'd4,
    CMD_COUNT     = 3'd5,
    CMD_DISPLAY   = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

endpackage

`default_nettype wire

/* rtl/bll_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module bll_mem #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IDX_W    = $clog2(CAPACITY)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           rd_en_i,
  input  wire logic [IDX_W-1:0]               rd_addr_i,
  input  wire logic [IDX_W-1:0]               wr_addr_i,
  input  wire logic                           lk_we_i,
  input  wire logic [IDX_W-1:0]               lk_wdata_i,
  input  wire logic                           val_we_i,
  input  wire logic signed [bll_pkg::VALUE_W-1:0] val_wdata_i,
  output logic      [IDX_W-1:0]               rd_link_o,
  output logic signed [bll_pkg::VALUE_W-1:0]  rd_value_o
);
  import bll_pkg::*;

  logic [IDX_W-1:0]          link_mem_q [CAPACITY];
  logic signed [VALUE_W-1:0] value_mem_q [CAPACITY];
  logic [CAPACITY-1:0]       link_ok_q;
  logic [IDX_W-1:0]          link_rd_q;
  logic                      ok_rd_q;
  logic [IDX_W-1:0]          addr_rd_q;
  logic [IDX_W-1:0]          chain_link;

  // Link store and value store, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (lk_we_i) begin
      link_mem_q[wr_addr_i] <= lk_wdata_i;
    end
    if (val_we_i) begin
      value_mem_q[wr_addr_i] <= val_wdata_i;
    end
    if (rd_en_i) begin
      link_rd_q  <= link_mem_q[rd_addr_i];
      rd_value_o <= value_mem_q[rd_addr_i];
      ok_rd_q    <= link_ok_q[rd_addr_i];
      addr_rd_q  <= rd_addr_i;
    end
  end

  // Mark links once written; unwritten links read as the initial free chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_ok_q <= '0;
    end else if (lk_we_i) begin
      link_ok_q[wr_addr_i] <= 1'b1;
    end
  end

  assign chain_link = (addr_rd_q == IDX_W'(CAPACITY - 1)) ? '0 : addr_rd_q + IDX_W'(1);
  assign rd_link_o  = ok_rd_q ? link_rd_q : chain_link;

endmodule

`default_nettype wire

/* rtl/bll_obuf.sv */
`timescale 1ns / 1ps
`default_nettype none

module bll_obuf #(
  parameter int unsigned W = 39
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_valid_i,
  output logic              push_ready_o,
  input  wire logic [W-1:0] push_data_i,
  input  wire logic         push_last_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [W-1:0]      out_data_o,
  output logic              out_last_o
);

  logic full_q;
  logic full_d;

  assign push_ready_o = !full_q || out_ready_i;
  assign out_valid_o  = full_q;

  // Track whether a word waits at the output
  always_comb begin
    full_d = full_q;
    if (push_valid_i && push_ready_o) begin
      full_d = 1'b1;
    end else if (out_ready_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  // Load the word on every push
  always_ff @(posedge clk_i) begin
    if (push_valid_i && push_ready_o) begin
      out_data_o <= push_data_i;
      out_last_o <= push_last_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/bll_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module bll_seq #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IDX_W    = $clog2(CAPACITY),
  parameter int unsigned LEN_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // command side
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [bll_pkg::CMD_W-1:0]          in_cmd_i,
  input  wire logic signed [bll_pkg::VALUE_W-1:0] in_value_i,
  input  wire logic [bll_pkg::POS_W-1:0]          in_pos_i,
  // result side
  output logic                                    res_valid_o,
  input  wire logic                               res_ready_i,
  output bll_pkg::status_e                        res_status_o,
  output logic signed [bll_pkg::VALUE_W-1:0]      res_data_o,
  output logic                                    res_last_o,
  output logic [LEN_W-1:0]                        res_len_o,
  // store port
  output logic                                    mem_rd_en_o,
  output logic [IDX_W-1:0]                        mem_rd_addr_o,
  output logic [IDX_W-1:0]                        mem_wr_addr_o,
  output logic                                    mem_lk_we_o,
  output logic [IDX_W-1:0]                        mem_lk_wdata_o,
  output logic                                    mem_val_we_o,
  output logic signed [bll_pkg::VALUE_W-1:0]      mem_val_wdata_o,
  input  wire logic [IDX_W-1:0]                   mem_rd_link_i,
  input  wire logic signed [bll_pkg::VALUE_W-1:0] mem_rd_value_i
);
  import bll_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_ALLOC    = 4'd2;
  localparam logic [3:0] S_UNHEAD   = 4'd3;
  localparam logic [3:0] S_WALK     = 4'd4;
  localparam logic [3:0] S_SPLICE   = 4'd5;
  localparam logic [3:0] S_GIVE     = 4'd6;
  localparam logic [3:0] S_DISP     = 4'd7;
  localparam logic [3:0] S_RESP     = 4'd8;

  logic [3:0]                state_q, state_d;
  logic [IDX_W-1:0]          head_q, head_d;
  logic [IDX_W-1:0]          free_q, free_d;
  logic [LEN_W-1:0]          count_q, count_d;
  status_e                   status_q, status_d;
  logic [CMD_W-1:0]          cmd_q, cmd_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic [POS_W-1:0]          pos_q, pos_d;
  logic [IDX_W-1:0]          ptr_q, ptr_d;
  logic [IDX_W-1:0]          aux_q, aux_d;
  logic [IDX_W-1:0]          steps_q, steps_d;
  logic [LEN_W-1:0]          rem_q, rem_d;
  logic [LEN_W-1:0]          place;
  logic                      is_full;
  logic                      is_empty;
  logic                      bad_pos;

  assign is_full   = (count_q == LEN_W'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign bad_pos   = (pos_q == '0) || (pos_q > POS_W'(count_q));
  assign res_len_o = count_q;

  // Pick the 0-based place a delete removes
  always_comb begin
    case (cmd_e'(cmd_q))
      CMD_DEL_BACK: place = count_q - LEN_W'(1);
      CMD_DEL_AT:   place = pos_q[LEN_W-1:0] - LEN_W'(1);
      default:      place = '0;
    endcase
  end

  // Sequence each command through reads and write-backs of the store
  always_comb begin
    state_d         = state_q;
    head_d          = head_q;
    free_d          = free_q;
    count_d         = count_q;
    status_d        = status_q;
    cmd_d           = cmd_q;
    value_d         = value_q;
    pos_d           = pos_q;
    ptr_d           = ptr_q;
    aux_d           = aux_q;
    steps_d         = steps_q;
    rem_d           = rem_q;
    in_ready_o      = 1'b0;
    res_valid_o     = 1'b0;
    res_status_o    = status_q;
    res_data_o      = '0;
    res_last_o      = 1'b1;
    mem_rd_en_o     = 1'b0;
    mem_rd_addr_o   = head_q;
    mem_wr_addr_o   = aux_q;
    mem_lk_we_o     = 1'b0;
    mem_lk_wdata_o  = free_q;
    mem_val_we_o    = 1'b0;
    mem_val_wdata_o = value_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = in_cmd_i;
          value_d = in_value_i;
          pos_d   = in_pos_i;
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        status_d = ST_OK;
        unique case (cmd_e'(cmd_q)) inside
          CMD_INS_FRONT, CMD_INS_BACK: begin
            if (is_full) begin
              status_d = ST_FULL;
              state_d  = S_RESP;
            end else begin
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = free_q;
              aux_d         = free_q;
              state_d       = S_ALLOC;
            end
          end
          CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
            if (is_empty) begin
              status_d = ST_EMPTY;
              state_d  = S_RESP;
            end else if ((cmd_e'(cmd_q) == CMD_DEL_AT) && bad_pos) begin
              status_d = ST_BADPOS;
              state_d  = S_RESP;
            end else begin
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = head_q;
              if (place == '0) begin
                state_d = S_UNHEAD;
              end else begin
                ptr_d   = head_q;
                steps_d = IDX_W'(place - LEN_W'(1));
                state_d = S_WALK;
              end
            end
          end
          CMD_COUNT: begin
            state_d = S_RESP;
          end
          CMD_DISPLAY: begin
            if (is_empty) begin
              status_d = ST_EMPTY;
              state_d  = S_RESP;
            end else begin
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = head_q;
              rem_d         = count_q;
              state_d       = S_DISP;
            end
          end
          default: begin
            // unused code: drop the word without a result
            state_d = S_IDLE;
          end
        endcase
      end

      S_ALLOC: begin
        // link read of the taken entry is the next free entry
        free_d        = mem_rd_link_i;
        mem_val_we_o  = 1'b1;
        mem_lk_we_o   = 1'b1;
        if (cmd_e'(cmd_q) == CMD_INS_FRONT) begin
          mem_lk_wdata_o = head_q;
          head_d         = aux_q;
          count_d        = count_q + LEN_W'(1);
          state_d        = S_RESP;
        end else begin
          mem_lk_wdata_o = '0;
          if (is_empty) begin
            head_d  = aux_q;
            count_d = count_q + LEN_W'(1);
            state_d = S_RESP;
          end else begin
            mem_rd_en_o   = 1'b1;
            mem_rd_addr_o = head_q;
            ptr_d         = head_q;
            steps_d       = IDX_W'(count_q - LEN_W'(1));
            state_d       = S_WALK;
          end
        end
      end

      S_UNHEAD: begin
        head_d         = mem_rd_link_i;
        mem_lk_we_o    = 1'b1;
        mem_wr_addr_o  = head_q;
        mem_lk_wdata_o = free_q;
        free_d         = head_q;
        count_d        = count_q - LEN_W'(1);
        state_d        = S_RESP;
      end

      S_WALK: begin
        if (steps_q != '0) begin
          // advance one link
          ptr_d         = mem_rd_link_i;
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = mem_rd_link_i;
          steps_d       = steps_q - IDX_W'(1);
        end else if (cmd_e'(cmd_q) == CMD_INS_BACK) begin
          // ptr is the tail: hang the new entry behind it
          mem_lk_we_o    = 1'b1;
          mem_wr_addr_o  = ptr_q;
          mem_lk_wdata_o = aux_q;
          count_d        = count_q + LEN_W'(1);
          state_d        = S_RESP;
        end else begin
          // ptr precedes the victim: fetch the victim's link
          aux_d         = mem_rd_link_i;
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = mem_rd_link_i;
          state_d       = S_SPLICE;
        end
      end

      S_SPLICE: begin
        mem_lk_we_o    = 1'b1;
        mem_wr_addr_o  = ptr_q;
        mem_lk_wdata_o = mem_rd_link_i;
        state_d        = S_GIVE;
      end

      S_GIVE: begin
        mem_lk_we_o    = 1'b1;
        mem_wr_addr_o  = aux_q;
        mem_lk_wdata_o = free_q;
        free_d         = aux_q;
        count_d        = count_q - LEN_W'(1);
        state_d        = S_RESP;
      end

      S_DISP: begin
        res_valid_o  = 1'b1;
        res_status_o = ST_OK;
        res_data_o   = mem_rd_value_i;
        res_last_o   = (rem_q == LEN_W'(1));
        if (res_ready_i) begin
          rem_d = rem_q - LEN_W'(1);
          if (rem_q == LEN_W'(1)) begin
            state_d = S_IDLE;
          end else begin
            mem_rd_en_o   = 1'b1;
            mem_rd_addr_o = mem_rd_link_i;
          end
        end
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      free_q   <= '0;
      count_q  <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      free_q   <= free_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  // Working registers of the current command
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    value_q <= value_d;
    pos_q   <= pos_d;
    ptr_q   <= ptr_d;
    aux_q   <= aux_d;
    steps_q <= steps_d;
    rem_q   <= rem_d;
  end

endmodule

`default_nettype wire

/* rtl/bounded_linked_list_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Word contents (low bits first)                      Marker
// s_axis    in   cmd[2:0] value[34:3] position[42:35], zero pad      -
// m_axis    out  status[1:0] data_out[33:2] length[38:34], zero pad  tlast
//
// Store: one link and one value memory with a registered read, one link per cycle.
// Count and status-only results go straight to the response; insert front and delete front touch only the head.
// Insert back onto n entries walks to the tail; delete at p > 1 (p = n for delete back) walks to entry p - 1.
// Display reads the values in list order. Reset empties the list at once (no sweep).
// A stalled m_axis holds the sequencer; s_axis is ready only between commands.

`include "bounded_linked_list_engine_defines.svh"

module bounded_linked_list_engine #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned IDX_W   = $clog2(CAPACITY),
  localparam int unsigned LEN_W   = $clog2(CAPACITY + 1),
  localparam int unsigned RES_W   = bll_pkg::STATUS_W + bll_pkg::VALUE_W + LEN_W,
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // cmd, value, position
  input  wire logic [bll_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // status, data_out, length
  output logic [OUT_TDATA_W-1:0]               m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import bll_pkg::*;

  localparam int unsigned VAL_LO = CMD_W;
  localparam int unsigned POS_LO = CMD_W + VALUE_W;

  logic                      res_valid;
  logic                      res_ready;
  status_e                   res_status;
  logic signed [VALUE_W-1:0] res_data;
  logic                      res_last;
  logic [LEN_W-1:0]          seq_len;
  logic [RES_W-1:0]          res_word;
  logic [RES_W-1:0]          out_word;
  logic                      mem_rd_en;
  logic [IDX_W-1:0]          mem_rd_addr;
  logic [IDX_W-1:0]          mem_wr_addr;
  logic                      mem_lk_we;
  logic [IDX_W-1:0]          mem_lk_wdata;
  logic                      mem_val_we;
  logic signed [VALUE_W-1:0] mem_val_wdata;
  logic [IDX_W-1:0]          mem_rd_link;
  logic signed [VALUE_W-1:0] mem_rd_value;
  logic                      idle_wait;
  logic                      run_word;

  // Command sequencer
  bll_seq #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .LEN_W    (LEN_W)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_cmd_i        (s_axis_tdata[CMD_W-1:0]),
    .in_value_i      (s_axis_tdata[VAL_LO +: VALUE_W]),
    .in_pos_i        (s_axis_tdata[POS_LO +: POS_W]),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_status_o    (res_status),
    .res_data_o      (res_data),
    .res_last_o      (res_last),
    .res_len_o       (seq_len),
    .mem_rd_en_o     (mem_rd_en),
    .mem_rd_addr_o   (mem_rd_addr),
    .mem_wr_addr_o   (mem_wr_addr),
    .mem_lk_we_o     (mem_lk_we),
    .mem_lk_wdata_o  (mem_lk_wdata),
    .mem_val_we_o    (mem_val_we),
    .mem_val_wdata_o (mem_val_wdata),
    .mem_rd_link_i   (mem_rd_link),
    .mem_rd_value_i  (mem_rd_value)
  );

  // Entry store
  bll_mem #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (mem_rd_en),
    .rd_addr_i   (mem_rd_addr),
    .wr_addr_i   (mem_wr_addr),
    .lk_we_i     (mem_lk_we),
    .lk_wdata_i  (mem_lk_wdata),
    .val_we_i    (mem_val_we),
    .val_wdata_i (mem_val_wdata),
    .rd_link_o   (mem_rd_link),
    .rd_value_o  (mem_rd_value)
  );

  // Pack result fields and register them toward m_axis
  assign res_word = {seq_len, res_data, res_status};

  bll_obuf #(
    .W (RES_W)
  ) u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (res_valid),
    .push_ready_o (res_ready),
    .push_data_i  (res_word),
    .push_last_i  (res_last),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (out_word),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_W'(out_word);

  // Checks
  assign idle_wait = s_axis_tready && !s_axis_tvalid;
  assign run_word  = res_valid && !res_last;

  `BLL_ASSERT_IMPL(a_len_bound, clk_i, rst_ni, 1'b1, seq_len <= LEN_W'(CAPACITY), "bad length")
  `BLL_ASSERT_IMPL(a_idle_no_result, clk_i, rst_ni, s_axis_tready, !res_valid, "result while idle")
  `BLL_ASSERT_NEXT(a_idle_len_stable, clk_i, rst_ni, idle_wait, $stable(seq_len), "length moved")
  `BLL_ASSERT_IMPL(a_run_ok, clk_i, rst_ni, run_word, res_status == ST_OK, "bad status in run")

endmodule

`default_nettype wire
